### rtl/core/tcw_pkg.sv
// shared widths, pipeline constants and the flag type for the cotangent weight block
`default_nettype none
package tcw_pkg;

  // root and divide steps resolved in each pipeline stage
  localparam int STEPS_PER_STG = 2;

  // datapath widths
  localparam int COORD_W = 32;
  localparam int DIFF_W  = 33;
  localparam int SQ_W    = 66;
  localparam int SUMSQ_W = 68;
  localparam int LEN_W   = SUMSQ_W / 2;
  localparam int P_W     = 35;
  localparam int T_W     = 2 * P_W;
  localparam int PROD_W  = 3 * P_W;
  localparam int RQ_W    = 68;
  localparam int RDEN_W  = P_W + 2;
  localparam int RAD_W   = RQ_W / 2;
  localparam int MAG_W   = 2 * P_W;
  localparam int CNUM_W  = MAG_W + 16;
  localparam int CQ_W    = 33;
  localparam int CDEN_W  = P_W + 2 + RAD_W;

  // per-corner flags plus the triangle's degenerate flag, carried along the first cotangent divider
  typedef struct packed {
    logic [2:0] neg;
    logic [2:0] ovf;
    logic       degen;
  } cot_flags_t;

endpackage
`default_nettype wire

### rtl/core/tcw_sqrt_pipe.sv
// pipelined restoring integer square root, a fixed number of root bits per stage
`default_nettype none
module tcw_sqrt_pipe
  import tcw_pkg::*;
#(
  parameter int IN_W = 68,
  parameter int SB_W = 1,
  localparam int RT_W = IN_W / 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [IN_W-1:0]   in_x,
  input  wire logic [SB_W-1:0]   in_sb,
  output logic                   out_valid,
  output logic [RT_W-1:0]        out_root,
  output logic [SB_W-1:0]        out_sb
);

  localparam int RM_W = RT_W + 3;
  localparam int NSTG = (RT_W + STEPS_PER_STG - 1) / STEPS_PER_STG;

  logic            vld_r  [NSTG];
  logic [RM_W-1:0] rem_r  [NSTG];
  logic [RT_W-1:0] root_r [NSTG];
  logic [IN_W-1:0] x_r    [NSTG];
  logic [SB_W-1:0] sb_r   [NSTG];

  for (genvar g = 0; g < NSTG; g++) begin : g_stg
    logic            cur_vld;
    logic [RM_W-1:0] cur_rem;
    logic [RT_W-1:0] cur_root;
    logic [IN_W-1:0] cur_x;
    logic [SB_W-1:0] cur_sb;
    logic [RM_W-1:0] rem_nxt;
    logic [RT_W-1:0] root_nxt;
    logic [IN_W-1:0] x_nxt;

    if (g == 0) begin : g_first
      assign cur_vld  = in_valid;
      assign cur_rem  = '0;
      assign cur_root = '0;
      assign cur_x    = in_x;
      assign cur_sb   = in_sb;
    end else begin : g_next
      assign cur_vld  = vld_r[g-1];
      assign cur_rem  = rem_r[g-1];
      assign cur_root = root_r[g-1];
      assign cur_x    = x_r[g-1];
      assign cur_sb   = sb_r[g-1];
    end

    // bring down two bits, try root*4+1
    always_comb begin
      logic [RM_W-1:0] trial;
      trial    = '0;
      rem_nxt  = cur_rem;
      root_nxt = cur_root;
      x_nxt    = cur_x;
      for (int k = 0; k < STEPS_PER_STG; k++) begin
        if (g * STEPS_PER_STG + k < RT_W) begin
          rem_nxt = {rem_nxt[RM_W-3:0], x_nxt[IN_W-1:IN_W-2]};
          x_nxt   = {x_nxt[IN_W-3:0], 2'b00};
          trial   = RM_W'({root_nxt, 2'b01});
          if (rem_nxt >= trial) begin
            rem_nxt  = rem_nxt - trial;
            root_nxt = {root_nxt[RT_W-2:0], 1'b1};
          end else begin
            root_nxt = {root_nxt[RT_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= cur_vld;
      end
      rem_r[g]  <= rem_nxt;
      root_r[g] <= root_nxt;
      x_r[g]    <= x_nxt;
      sb_r[g]   <= cur_sb;
    end
  end

  assign out_valid = vld_r[NSTG-1];
  assign out_root  = root_r[NSTG-1];
  assign out_sb    = sb_r[NSTG-1];

endmodule
`default_nettype wire

### rtl/core/tcw_div_pipe.sv
// pipelined restoring divider, quotient known to fit Q_W bits, a few bits per stage
`default_nettype none
module tcw_div_pipe
  import tcw_pkg::*;
#(
  parameter int N_W  = 105,
  parameter int D_W  = 37,
  parameter int Q_W  = 68,
  parameter int SB_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [N_W-1:0]    in_num,
  input  wire logic [D_W-1:0]    in_den,
  input  wire logic [SB_W-1:0]   in_sb,
  output logic                   out_valid,
  output logic [Q_W-1:0]         out_quo,
  output logic [SB_W-1:0]        out_sb
);

  localparam int NSTG = (Q_W + STEPS_PER_STG - 1) / STEPS_PER_STG;

  logic           vld_r [NSTG];
  logic [D_W-1:0] rem_r [NSTG];
  logic [D_W-1:0] den_r [NSTG];
  logic [Q_W-1:0] q_r   [NSTG];
  logic [Q_W-1:0] n_r   [NSTG];
  logic [SB_W-1:0] sb_r [NSTG];

  for (genvar g = 0; g < NSTG; g++) begin : g_stg
    logic            cur_vld;
    logic [D_W-1:0]  cur_rem;
    logic [D_W-1:0]  cur_den;
    logic [Q_W-1:0]  cur_q;
    logic [Q_W-1:0]  cur_n;
    logic [SB_W-1:0] cur_sb;
    logic [D_W-1:0]  rem_nxt;
    logic [Q_W-1:0]  q_nxt;
    logic [Q_W-1:0]  n_nxt;

    if (g == 0) begin : g_first
      // high numerator bits sit below the divisor, so they seed the remainder
      assign cur_vld = in_valid;
      assign cur_rem = D_W'(in_num[N_W-1:Q_W]);
      assign cur_den = in_den;
      assign cur_q   = '0;
      assign cur_n   = in_num[Q_W-1:0];
      assign cur_sb  = in_sb;
    end else begin : g_next
      assign cur_vld = vld_r[g-1];
      assign cur_rem = rem_r[g-1];
      assign cur_den = den_r[g-1];
      assign cur_q   = q_r[g-1];
      assign cur_n   = n_r[g-1];
      assign cur_sb  = sb_r[g-1];
    end

    // shift in a numerator bit, subtract when it fits
    always_comb begin
      logic [D_W:0] rem2;
      rem2    = '0;
      rem_nxt = cur_rem;
      q_nxt   = cur_q;
      n_nxt   = cur_n;
      for (int k = 0; k < STEPS_PER_STG; k++) begin
        if (g * STEPS_PER_STG + k < Q_W) begin
          rem2  = {rem_nxt, n_nxt[Q_W-1]};
          n_nxt = {n_nxt[Q_W-2:0], 1'b0};
          if (rem2 >= {1'b0, cur_den}) begin
            rem_nxt = D_W'(rem2 - {1'b0, cur_den});
            q_nxt   = {q_nxt[Q_W-2:0], 1'b1};
          end else begin
            rem_nxt = rem2[D_W-1:0];
            q_nxt   = {q_nxt[Q_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= cur_vld;
      end
      rem_r[g] <= rem_nxt;
      den_r[g] <= cur_den;
      q_r[g]   <= q_nxt;
      n_r[g]   <= n_nxt;
      sb_r[g]  <= cur_sb;
    end
  end

  assign out_valid = vld_r[NSTG-1];
  assign out_quo   = q_r[NSTG-1];
  assign out_sb    = sb_r[NSTG-1];

endmodule
`default_nettype wire

### rtl/core/triangle_cotangent_weights.sv
// top level: per-triangle cotangent weights, fully pipelined
//
// Takes one triangle (three Q16.16 vertices) in every clock cycle and gives
// the three corner cotangents, saturated Q16.16, plus a degenerate flag. The
// pipeline is built from the edge-length square roots (17 stages), the
// inradius divider (34 stages), the inradius square root (17 stages) and
// the cotangent dividers (17 stages), each resolving two bits per stage,
// plus ten stages of differences, multiplies and adds. The result strobe
// out_valid is high for one cycle per triangle; results must be taken when
// shown. busy is high only while reset is held.
`default_nettype none
module triangle_cotangent_weights
  import tcw_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [COORD_W-1:0] in_ax,
  input  wire logic signed [COORD_W-1:0] in_ay,
  input  wire logic signed [COORD_W-1:0] in_az,
  input  wire logic signed [COORD_W-1:0] in_bx,
  input  wire logic signed [COORD_W-1:0] in_by,
  input  wire logic signed [COORD_W-1:0] in_bz,
  input  wire logic signed [COORD_W-1:0] in_cx,
  input  wire logic signed [COORD_W-1:0] in_cy,
  input  wire logic signed [COORD_W-1:0] in_cz,
  output logic                           out_valid,
  output logic signed [COORD_W-1:0]      out_cot_at_a,
  output logic signed [COORD_W-1:0]      out_cot_at_b,
  output logic signed [COORD_W-1:0]      out_cot_at_c,
  output logic                           out_degenerate
);

  localparam int SQE_STG = (LEN_W + STEPS_PER_STG - 1) / STEPS_PER_STG;
  localparam int DVR_STG = (RQ_W + STEPS_PER_STG - 1) / STEPS_PER_STG;
  localparam int SQR_STG = (RAD_W + STEPS_PER_STG - 1) / STEPS_PER_STG;
  localparam int DVC_STG = (CQ_W + STEPS_PER_STG - 1) / STEPS_PER_STG;
  localparam int LAT     = 10 + SQE_STG + DVR_STG + SQR_STG + DVC_STG;
  localparam int RSB_W   = 1 + 3 * P_W;

  logic accept;
  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // vertex coordinates by vertex and axis
  logic signed [COORD_W-1:0] vtx [3][3];
  assign vtx[0][0] = in_ax;
  assign vtx[0][1] = in_ay;
  assign vtx[0][2] = in_az;
  assign vtx[1][0] = in_bx;
  assign vtx[1][1] = in_by;
  assign vtx[1][2] = in_bz;
  assign vtx[2][0] = in_cx;
  assign vtx[2][1] = in_cy;
  assign vtx[2][2] = in_cz;

  // stage 1: absolute coordinate differences, edge e is opposite vertex e
  logic              v1_r;
  logic [DIFF_W-1:0] ad_r  [3][3];
  logic [DIFF_W-1:0] ad_nxt[3][3];

  always_comb begin
    logic signed [DIFF_W-1:0] d;
    int                       i, j;
    for (int e = 0; e < 3; e++) begin
      i = (e == 0) ? 1 : 0;
      j = (e == 2) ? 1 : 2;
      for (int k = 0; k < 3; k++) begin
        d = DIFF_W'(vtx[i][k]) - DIFF_W'(vtx[j][k]);
        ad_nxt[e][k] = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
      end
    end
  end

  // stage 2: squares
  logic            v2_r;
  logic [SQ_W-1:0] sq_r [3][3];

  // stage 3: sums of squares
  logic               v3_r;
  logic [SUMSQ_W-1:0] ss_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    for (int e = 0; e < 3; e++) begin
      for (int k = 0; k < 3; k++) begin
        ad_r[e][k] <= ad_nxt[e][k];
        sq_r[e][k] <= SQ_W'(ad_r[e][k]) * SQ_W'(ad_r[e][k]);
      end
      ss_r[e] <= SUMSQ_W'(sq_r[e][0]) + SUMSQ_W'(sq_r[e][1]) + SUMSQ_W'(sq_r[e][2]);
    end
  end

  // edge lengths
  logic             len_vld;
  logic [LEN_W-1:0] len [3];

  tcw_sqrt_pipe #(.IN_W(SUMSQ_W), .SB_W(1)) u_sqrt_e0 (
    .clk(clk), .rst_n(rst_n), .in_valid(v3_r), .in_x(ss_r[0]), .in_sb(1'b0),
    .out_valid(len_vld), .out_root(len[0]), .out_sb()
  );
  tcw_sqrt_pipe #(.IN_W(SUMSQ_W), .SB_W(1)) u_sqrt_e1 (
    .clk(clk), .rst_n(rst_n), .in_valid(v3_r), .in_x(ss_r[1]), .in_sb(1'b0),
    .out_valid(), .out_root(len[1]), .out_sb()
  );
  tcw_sqrt_pipe #(.IN_W(SUMSQ_W), .SB_W(1)) u_sqrt_e2 (
    .clk(clk), .rst_n(rst_n), .in_valid(v3_r), .in_x(ss_r[2]), .in_sb(1'b0),
    .out_valid(), .out_root(len[2]), .out_sb()
  );

  // perimeter and u = p - 2l, clamped at zero
  logic           pv_r, tv_r, hv_r, mv_r;
  logic [P_W-1:0] p_r, pt_r, ph_r, pm_r;
  logic [P_W-1:0] u_r [3];
  logic [P_W-1:0] ut_r[3];
  logic [P_W-1:0] uh_r[3];
  logic [P_W-1:0] um_r[3];
  logic           pz_r, pzt_r, pzh_r, pzm_r;
  logic [P_W-1:0] p_nxt;
  logic [P_W-1:0] u_nxt [3];

  always_comb begin
    logic [P_W-1:0] twol;
    p_nxt = P_W'(len[0]) + P_W'(len[1]) + P_W'(len[2]);
    for (int e = 0; e < 3; e++) begin
      twol     = P_W'({len[e], 1'b0});
      u_nxt[e] = (p_nxt >= twol) ? p_nxt - twol : '0;
    end
  end

  // triple product u0*u1*u2, upper product split in two partial products
  logic [T_W-1:0]    t_r;
  logic [T_W-1:0]    plo_r, phi_r;
  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      tv_r <= 1'b0;
      hv_r <= 1'b0;
      mv_r <= 1'b0;
    end else begin
      pv_r <= len_vld;
      tv_r <= pv_r;
      hv_r <= tv_r;
      mv_r <= hv_r;
    end
    p_r   <= p_nxt;
    pz_r  <= (p_nxt == '0);
    u_r   <= u_nxt;
    t_r   <= T_W'(u_r[0]) * T_W'(u_r[1]);
    pt_r  <= p_r;
    pzt_r <= pz_r;
    ut_r  <= u_r;
    plo_r <= T_W'(t_r[P_W-1:0]) * T_W'(ut_r[2]);
    phi_r <= T_W'(t_r[T_W-1:P_W]) * T_W'(ut_r[2]);
    ph_r  <= pt_r;
    pzh_r <= pzt_r;
    uh_r  <= ut_r;
    prod_r <= PROD_W'(plo_r) + (PROD_W'(phi_r) << P_W);
    pm_r  <= ph_r;
    pzm_r <= pzh_r;
    um_r  <= uh_r;
  end

  // area term over 4p, then the inradius
  logic             rq_vld;
  logic [RQ_W-1:0]  rq;
  logic [RSB_W-1:0] rq_sb;
  logic             rad_vld;
  logic [RAD_W-1:0] rad;
  logic [RSB_W-1:0] rad_sb;

  tcw_div_pipe #(.N_W(PROD_W), .D_W(RDEN_W), .Q_W(RQ_W), .SB_W(RSB_W)) u_div_r (
    .clk(clk), .rst_n(rst_n), .in_valid(mv_r), .in_num(prod_r),
    .in_den({pm_r, 2'b00}), .in_sb({pzm_r, um_r[0], um_r[1], um_r[2]}),
    .out_valid(rq_vld), .out_quo(rq), .out_sb(rq_sb)
  );

  tcw_sqrt_pipe #(.IN_W(RQ_W), .SB_W(RSB_W)) u_sqrt_r (
    .clk(clk), .rst_n(rst_n), .in_valid(rq_vld), .in_x(rq), .in_sb(rq_sb),
    .out_valid(rad_vld), .out_root(rad), .out_sb(rad_sb)
  );

  // cotangent terms: u^2, (2r)^2 and 4ur per corner
  logic [P_W-1:0]    ur [3];
  assign ur[0] = rad_sb[3*P_W-1:2*P_W];
  assign ur[1] = rad_sb[2*P_W-1:P_W];
  assign ur[2] = rad_sb[P_W-1:0];

  logic              c1v_r, c2v_r;
  logic [MAG_W-1:0]  uu_r [3];
  logic [MAG_W-1:0]  rr4_r;
  logic [CDEN_W-1:0] den_r [3];
  logic [CDEN_W-1:0] den2_r[3];
  logic              dg1_r;
  logic [CNUM_W-1:0] num_r [3];
  cot_flags_t        fl_r;
  cot_flags_t        fl_nxt;
  logic [CNUM_W-1:0] num_nxt [3];

  always_comb begin
    logic [MAG_W-1:0] mag;
    fl_nxt.degen = dg1_r;
    for (int e = 0; e < 3; e++) begin
      fl_nxt.neg[e] = (uu_r[e] < rr4_r);
      mag = fl_nxt.neg[e] ? rr4_r - uu_r[e] : uu_r[e] - rr4_r;
      num_nxt[e] = {mag, 16'h0000};
      // quotient needs more than CQ_W bits
      fl_nxt.ovf[e] = (CDEN_W'(num_nxt[e][CNUM_W-1:CQ_W]) >= den_r[e]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1v_r <= 1'b0;
      c2v_r <= 1'b0;
    end else begin
      c1v_r <= rad_vld;
      c2v_r <= c1v_r;
    end
    for (int e = 0; e < 3; e++) begin
      uu_r[e]  <= MAG_W'(ur[e]) * MAG_W'(ur[e]);
      den_r[e] <= CDEN_W'({ur[e], 2'b00}) * CDEN_W'(rad);
    end
    rr4_r  <= MAG_W'({rad, 1'b0}) * MAG_W'({rad, 1'b0});
    dg1_r  <= rad_sb[RSB_W-1] | (rad == '0);
    num_r  <= num_nxt;
    den2_r <= den_r;
    fl_r   <= fl_nxt;
  end

  // cotangent magnitudes
  logic            cq_vld;
  logic [CQ_W-1:0] cq [3];
  cot_flags_t      cq_fl;

  tcw_div_pipe #(.N_W(CNUM_W), .D_W(CDEN_W), .Q_W(CQ_W), .SB_W($bits(cot_flags_t))) u_div_c0 (
    .clk(clk), .rst_n(rst_n), .in_valid(c2v_r), .in_num(num_r[0]), .in_den(den2_r[0]),
    .in_sb(fl_r), .out_valid(cq_vld), .out_quo(cq[0]), .out_sb(cq_fl)
  );
  tcw_div_pipe #(.N_W(CNUM_W), .D_W(CDEN_W), .Q_W(CQ_W), .SB_W(1)) u_div_c1 (
    .clk(clk), .rst_n(rst_n), .in_valid(c2v_r), .in_num(num_r[1]), .in_den(den2_r[1]),
    .in_sb(1'b0), .out_valid(), .out_quo(cq[1]), .out_sb()
  );
  tcw_div_pipe #(.N_W(CNUM_W), .D_W(CDEN_W), .Q_W(CQ_W), .SB_W(1)) u_div_c2 (
    .clk(clk), .rst_n(rst_n), .in_valid(c2v_r), .in_num(num_r[2]), .in_den(den2_r[2]),
    .in_sb(1'b0), .out_valid(), .out_quo(cq[2]), .out_sb()
  );

  // sign, saturation and degenerate zeroing
  logic [COORD_W-1:0] cot_nxt [3];
  logic [COORD_W-1:0] cot_r   [3];
  logic               ov_r;
  logic               dg_r;

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      if (cq_fl.degen) begin
        cot_nxt[e] = '0;
      end else if (!cq_fl.neg[e]) begin
        cot_nxt[e] = (cq_fl.ovf[e] || cq[e] > CQ_W'(32'h7FFF_FFFF)) ?
                     32'h7FFF_FFFF : cq[e][COORD_W-1:0];
      end else begin
        cot_nxt[e] = (cq_fl.ovf[e] || cq[e] > CQ_W'(32'h8000_0000)) ?
                     32'h8000_0000 : COORD_W'(-cq[e]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= cq_vld;
    end
    cot_r <= cot_nxt;
    dg_r  <= cq_fl.degen;
  end

  assign out_valid      = ov_r;
  assign out_cot_at_a   = cot_r[0];
  assign out_cot_at_b   = cot_r[1];
  assign out_cot_at_c   = cot_r[2];
  assign out_degenerate = dg_r;

  // a result strobe always traces back to a transfer a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result without matching input transfer");

  // degenerate results carry zero cotangents
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_cot_at_a == '0 && out_cot_at_b == '0 && out_cot_at_c == '0)
    else $error("degenerate result with nonzero cotangent");

  // a triangle with all vertices equal comes out degenerate
  a_point_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(accept && in_ax == in_bx && in_bx == in_cx &&
      in_ay == in_by && in_by == in_cy && in_az == in_bz && in_bz == in_cz, LAT)
      |-> out_degenerate)
    else $error("collapsed triangle not flagged degenerate");

endmodule
`default_nettype wire
